[sv/assert_macros.svh]
// Assertion helpers. Each macro expects signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ppghr_pkg.sv]
package ppghr_pkg;

    localparam int RATE_HISTORY_DEF = 7;

    localparam int WIN_LEN    = 7;
    localparam int WIN_CENTER = 3;
    localparam int WIN_FILL_W = $clog2(WIN_LEN + 1);

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int RATE_W   = 8;

    localparam int DIV_DVD_W  = 16;
    localparam int DIV_DVS_W  = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_DVD_W);

    localparam logic [CFG_W-1:0]     MIN_INTERVAL_RST = 16'd425;
    localparam logic [DIV_DVD_W-1:0] MS_PER_MINUTE    = 16'd60000;
    localparam logic [RATE_W-1:0]    RATE_MAX         = 8'hFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;
        logic rate_start;
        logic store;
        logic sum_clear;
        logic sum_step;
        logic held_load;
        logic out_load;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic peak_ok;
        logic div_busy;
        logic mean_req;
        logic sum_last;
    } status_t;

endpackage

[sv/ppghr_div.sv]
module ppghr_div
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [ppghr_pkg::DIV_DVD_W-1:0]    dividend,
    input  logic [ppghr_pkg::DIV_DVS_W-1:0]    divisor,
    output logic                               busy,
    output logic [ppghr_pkg::DIV_DVD_W-1:0]    quotient
);

    logic                               busy_reg;
    logic [ppghr_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [ppghr_pkg::DIV_DVS_W-1:0]    rem_reg;
    logic [ppghr_pkg::DIV_DVS_W-1:0]    rem_next;
    logic [ppghr_pkg::DIV_DVS_W-1:0]    dvs_reg;
    logic [ppghr_pkg::DIV_DVD_W-1:0]    quo_reg;
    logic [ppghr_pkg::DIV_DVS_W:0]      trial;
    logic [ppghr_pkg::DIV_DVS_W:0]      diff;
    logic                               fits;

    // One restoring step per cycle, most significant quotient bit first.
    // The remainder always stays below the divisor, so it fits in 32 bits.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[ppghr_pkg::DIV_DVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[ppghr_pkg::DIV_DVS_W-1:0] : trial[ppghr_pkg::DIV_DVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            quo_reg  <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[ppghr_pkg::DIV_DVD_W-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == ppghr_pkg::DIV_CNT_W'(ppghr_pkg::DIV_DVD_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[sv/ppghr_datapath.sv]
module ppghr_datapath
#(
    parameter int RATE_HISTORY = ppghr_pkg::RATE_HISTORY_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [ppghr_pkg::CFG_W-1:0]       cfg_write_data,
    input  logic [ppghr_pkg::SAMPLE_W-1:0]    sample,
    input  logic [ppghr_pkg::TIME_W-1:0]      timestamp_ms,
    input  ppghr_pkg::cmd_t                   cmd,
    output ppghr_pkg::status_t                status,
    output logic [ppghr_pkg::RATE_W-1:0]      heart_rate_bpm
);

    localparam int CNT_W = $clog2(RATE_HISTORY + 1);
    localparam int IDX_W = $clog2(RATE_HISTORY);
    localparam int SUM_W = $clog2(RATE_HISTORY * 255 + 1);

    // The mean is a multiply by a rounded-up reciprocal of the history length.
    // With this shift it is exact for every sum that fits in SUM_W bits.
    localparam int MEAN_SHIFT = SUM_W + $clog2(RATE_HISTORY);
    localparam int RECIP_W    = SUM_W + 2;
    localparam logic [RECIP_W-1:0] MEAN_RECIP =
        RECIP_W'(((1 << MEAN_SHIFT) + RATE_HISTORY - 1) / RATE_HISTORY);

    logic [ppghr_pkg::CFG_W-1:0]       min_int_reg;
    logic [ppghr_pkg::SAMPLE_W-1:0]    samp_win_reg [ppghr_pkg::WIN_LEN];
    logic [ppghr_pkg::TIME_W-1:0]      time_win_reg [ppghr_pkg::WIN_LEN];
    logic [ppghr_pkg::WIN_FILL_W-1:0]  fill_reg;
    logic [ppghr_pkg::TIME_W-1:0]      last_peak_reg;
    logic [ppghr_pkg::RATE_W-1:0]      hist_reg [RATE_HISTORY];
    logic [CNT_W-1:0]                  count_reg;
    logic [ppghr_pkg::RATE_W-1:0]      held_reg;
    logic [SUM_W-1:0]                  sum_reg;
    logic [IDX_W-1:0]                  idx_reg;
    logic [ppghr_pkg::RATE_W-1:0]      out_data_reg;

    logic [ppghr_pkg::SAMPLE_W-1:0]    center;
    logic                              is_peak;
    logic [ppghr_pkg::TIME_W-1:0]      interval;
    logic [ppghr_pkg::RATE_W-1:0]      rate8;
    logic                              div_start;
    logic [ppghr_pkg::DIV_DVD_W-1:0]   div_dividend;
    logic [ppghr_pkg::DIV_DVS_W-1:0]   div_divisor;
    logic                              div_busy;
    logic [ppghr_pkg::DIV_DVD_W-1:0]   div_quo;
    logic [SUM_W+RECIP_W-1:0]          mean_prod;
    logic [ppghr_pkg::RATE_W-1:0]      mean_rate;

    // Peak test; window entries not yet filled still hold their reset zero.
    always_comb
    begin
        center  = samp_win_reg[ppghr_pkg::WIN_CENTER];
        is_peak = (center >  samp_win_reg[0]) && (center >= samp_win_reg[1]) &&
                  (center >= samp_win_reg[2]) && (center >= samp_win_reg[4]) &&
                  (center >= samp_win_reg[5]) && (center >  samp_win_reg[6]);
        interval = time_win_reg[ppghr_pkg::WIN_CENTER] - last_peak_reg;
    end

    assign rate8 = (|div_quo[ppghr_pkg::DIV_DVD_W-1:ppghr_pkg::RATE_W]) ?
                   ppghr_pkg::RATE_MAX : div_quo[ppghr_pkg::RATE_W-1:0];

    assign div_start    = cmd.rate_start;
    assign div_dividend = ppghr_pkg::MS_PER_MINUTE;
    assign div_divisor  = interval;

    ppghr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign mean_prod = {{RECIP_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, MEAN_RECIP};
    assign mean_rate = mean_prod[MEAN_SHIFT +: ppghr_pkg::RATE_W];

    always_comb
    begin
        status.peak_ok  = is_peak && (interval > {16'd0, min_int_reg});
        status.div_busy = div_busy;
        status.mean_req = (count_reg == CNT_W'(RATE_HISTORY - 1)) && (rate8 != '0);
        status.sum_last = (idx_reg == IDX_W'(RATE_HISTORY - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_int_reg <= ppghr_pkg::MIN_INTERVAL_RST;
        end
        else if (cfg_write_en)
        begin
            min_int_reg <= cfg_write_data;
        end
    end

    // The window fills from the front, then shifts toward index zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ppghr_pkg::WIN_LEN; i++)
            begin
                samp_win_reg[i] <= '0;
                time_win_reg[i] <= '0;
            end
            fill_reg <= '0;
        end
        else if (cmd.push)
        begin
            if (fill_reg == ppghr_pkg::WIN_FILL_W'(ppghr_pkg::WIN_LEN))
            begin
                for (int i = 0; i < ppghr_pkg::WIN_LEN - 1; i++)
                begin
                    samp_win_reg[i] <= samp_win_reg[i + 1];
                    time_win_reg[i] <= time_win_reg[i + 1];
                end
                samp_win_reg[ppghr_pkg::WIN_LEN - 1] <= sample;
                time_win_reg[ppghr_pkg::WIN_LEN - 1] <= timestamp_ms;
            end
            else
            begin
                for (int i = 0; i < ppghr_pkg::WIN_LEN; i++)
                begin
                    if (fill_reg == ppghr_pkg::WIN_FILL_W'(i))
                    begin
                        samp_win_reg[i] <= sample;
                        time_win_reg[i] <= timestamp_ms;
                    end
                end
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // A full history drops its oldest rate as each item arrives.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RATE_HISTORY; i++)
            begin
                hist_reg[i] <= '0;
            end
            count_reg     <= '0;
            last_peak_reg <= '0;
        end
        else if (cmd.push)
        begin
            if (count_reg == CNT_W'(RATE_HISTORY))
            begin
                for (int i = 0; i < RATE_HISTORY - 1; i++)
                begin
                    hist_reg[i] <= hist_reg[i + 1];
                end
                hist_reg[RATE_HISTORY - 1] <= '0;
                count_reg <= CNT_W'(RATE_HISTORY - 1);
            end
        end
        else if (cmd.store)
        begin
            hist_reg[count_reg[IDX_W-1:0]] <= rate8;
            count_reg     <= count_reg + 1'b1;
            last_peak_reg <= time_win_reg[ppghr_pkg::WIN_CENTER];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            idx_reg <= '0;
        end
        else if (cmd.sum_clear)
        begin
            sum_reg <= '0;
            idx_reg <= '0;
        end
        else if (cmd.sum_step)
        begin
            sum_reg <= sum_reg + SUM_W'(hist_reg[idx_reg]);
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (cmd.held_load)
        begin
            held_reg <= mean_rate;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= held_reg;
        end
    end

    assign heart_rate_bpm = out_data_reg;

endmodule

[sv/ppghr_ctrl.sv]
module ppghr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  ppghr_pkg::status_t    status,
    output ppghr_pkg::cmd_t       cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_TEST     = 6'b000010,
        ST_DIV_RATE = 6'b000100,
        ST_SUM      = 6'b001000,
        ST_MEAN     = 6'b010000,
        ST_FINISH   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (status.peak_ok)
                begin
                    cmd.rate_start = 1'b1;
                    state_next     = ST_DIV_RATE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV_RATE:
            begin
                if (!status.div_busy)
                begin
                    cmd.store = 1'b1;
                    if (status.mean_req)
                    begin
                        cmd.sum_clear = 1'b1;
                        state_next    = ST_SUM;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (status.sum_last)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                cmd.held_load = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[sv/ppg_heart_rate_estimator_core.sv]
// PPG heart-rate estimator.
// Input channel: in_valid / in_stall with sample and timestamp_ms; an item is
// taken at a clock edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with heart_rate_bpm; every input item
// yields exactly one output item carrying the held averaged rate.
// Configuration: cfg_write_en / cfg_write_data set the minimum peak spacing
// in milliseconds; write it only while the block is idle.
// Sequence: an accepted item is tested for a peak; a recorded peak then runs the
// divider for its rate and stores it; when that peak also completes a full
// history with a nonzero rate, the history is summed and its mean is held.
// The rate comes from a 16-step restoring divider and the sum takes one entry
// per cycle; the mean is a combinational reciprocal multiply into the held rate.
// One item is in work at a time; the next one is taken the cycle after the
// result is registered.
// A finished result waits in the output register while out_stall is high; a next
// item is still taken, but its own result holds in_stall high until the register frees.
// Reset clears the windows, the rate history and the held rate to zero and
// sets the minimum peak spacing to 425 ms.
`include "assert_macros.svh"

module ppg_heart_rate_estimator_core
#(
    parameter int RATE_HISTORY = ppghr_pkg::RATE_HISTORY_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [ppghr_pkg::CFG_W-1:0]       cfg_write_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ppghr_pkg::SAMPLE_W-1:0]    sample,
    input  logic [ppghr_pkg::TIME_W-1:0]      timestamp_ms,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ppghr_pkg::RATE_W-1:0]      heart_rate_bpm
);

    ppghr_pkg::cmd_t    cmd;
    ppghr_pkg::status_t status;

    ppghr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ppghr_datapath #(
        .RATE_HISTORY (RATE_HISTORY)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .sample         (sample),
        .timestamp_ms   (timestamp_ms),
        .cmd            (cmd),
        .status         (status),
        .heart_rate_bpm (heart_rate_bpm)
    );

    // An accepted item keeps the input side closed while it is worked on.
    `PPG_ASSERT_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall, "accept not followed by stall")
    // The divider is never running while the block waits for a new item.
    `PPG_ASSERT_SAME(a_idle_div_quiet, !in_stall, !status.div_busy, "divider busy while idle")
    // A new result only appears at the end of an item's work.
    `PPG_ASSERT_SAME(a_result_after_work, $rose(out_valid), $past(in_stall), "result without work")
    // A push never coincides with an output load or a history store.
    `PPG_ASSERT_SAME(a_single_cmd, cmd.push, !cmd.out_load && !cmd.store, "conflicting commands")

endmodule
